// File: rtl/wstt_pkg.sv
// ----------------------------------------------------------------------------
// wstt_pkg
// Shared widths, register codes, order sides and controller/datapath structs
// for the weighted signal threshold trigger.
// ----------------------------------------------------------------------------
package wstt_pkg;

	localparam int FACTORS_DEF = 6;
	localparam int NUM_WEIGHTS = 6;

	localparam int SLOT_W     = 3;
	localparam int VAL_W      = 32;
	localparam int INST_W     = 16;
	localparam int THR_W      = 47;
	localparam int CNT_W      = 3;
	localparam int WGT_W      = 16;
	localparam int WIDX_W     = 3;
	localparam int PROD_W     = VAL_W + WGT_W;
	localparam int SUM_W      = PROD_W + 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 47;

	localparam logic [THR_W-1:0] THR_RESET = 47'd268435456;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_THRESHOLD    = 3'd0,
		REG_FACTOR_COUNT = 3'd1,
		REG_WEIGHT_0     = 3'd2,
		REG_WEIGHT_1     = 3'd3,
		REG_WEIGHT_2     = 3'd4,
		REG_WEIGHT_3     = 3'd5,
		REG_WEIGHT_4     = 3'd6,
		REG_WEIGHT_5     = 3'd7
	} cfg_reg_t;

	// commands from the controller
	typedef struct packed {
		logic             load;
		logic             mul_en;
		logic             emit;
		logic [CNT_W-1:0] idx;
	} wstt_cmd_t;

	// status back to the controller
	typedef struct packed {
		logic             slot_ok;
		logic [CNT_W-1:0] used;
		logic             fire;
		logic             out_free;
	} wstt_sts_t;

endpackage

// File: rtl/wstt_in_if.sv
// ----------------------------------------------------------------------------
// wstt_in_if
// Factor update channel: slot, value and instrument id.
// ----------------------------------------------------------------------------
interface wstt_in_if;
	logic                               valid;
	logic                               ready;
	logic [wstt_pkg::SLOT_W-1:0]        factor_slot;
	logic signed [wstt_pkg::VAL_W-1:0]  factor_value;
	logic [wstt_pkg::INST_W-1:0]        instrument;

	modport source (output valid, factor_slot, factor_value, instrument, input ready);
	modport sink (input valid, factor_slot, factor_value, instrument, output ready);
endinterface

// File: rtl/wstt_out_if.sv
// ----------------------------------------------------------------------------
// wstt_out_if
// Order channel: side and instrument id.
// ----------------------------------------------------------------------------
interface wstt_out_if;
	logic                        valid;
	logic                        ready;
	logic                        side;
	logic [wstt_pkg::INST_W-1:0] order_instrument;

	modport source (output valid, side, order_instrument, input ready);
	modport sink (input valid, side, order_instrument, output ready);
endinterface

// File: rtl/wstt_cfg_if.sv
// ----------------------------------------------------------------------------
// wstt_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface wstt_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [wstt_pkg::CFG_IDX_W-1:0]  reg_index;
	logic [wstt_pkg::CFG_DATA_W-1:0] wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: rtl/wstt_ctrl.sv
// ----------------------------------------------------------------------------
// wstt_ctrl
// Sequencer: takes an update, steps the multiply-accumulate over the slots
// in use, then compares and on a hit hands an order to the output register.
// ----------------------------------------------------------------------------
module wstt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wstt_pkg::wstt_sts_t sts,
	output wstt_pkg::wstt_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_ADD  = 4'b0100,
		ST_CMP  = 4'b1000
	} state_t;

	state_t                     state_q, state_n;
	logic [wstt_pkg::CNT_W-1:0] idx_q, idx_n;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_n    = state_q;
		idx_n      = idx_q;
		cmd        = '0;
		cmd.idx    = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.slot_ok) begin
					cmd.load = 1'b1;
					idx_n    = '0;
					state_n  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				if (idx_q == sts.used - wstt_pkg::CNT_W'(1)) begin
					state_n = ST_ADD;
				end else begin
					idx_n = idx_q + wstt_pkg::CNT_W'(1);
				end
			end
			// last product lands in the accumulator
			ST_ADD: begin
				state_n = ST_CMP;
			end
			ST_CMP: begin
				if (!sts.fire) begin
					state_n = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_n  = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_n;
			idx_q   <= idx_n;
		end
	end

endmodule

// File: rtl/wstt_dp.sv
// ----------------------------------------------------------------------------
// wstt_dp
// Datapath: configuration registers, factor store, registered multiplier,
// accumulator, threshold compare and order output register.
// ----------------------------------------------------------------------------
module wstt_dp #(
	parameter int FACTORS = wstt_pkg::FACTORS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic [wstt_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [wstt_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic [wstt_pkg::SLOT_W-1:0]           in_slot,
	input  logic signed [wstt_pkg::VAL_W-1:0]     in_value,
	input  logic [wstt_pkg::INST_W-1:0]           in_inst,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic                                  out_side,
	output logic [wstt_pkg::INST_W-1:0]           out_inst,
	input  wstt_pkg::wstt_cmd_t                   cmd,
	output wstt_pkg::wstt_sts_t                   sts
);

	localparam int IDX_W = (FACTORS > 1) ? $clog2(FACTORS) : 1;

	logic [wstt_pkg::THR_W-1:0]        threshold_q;
	logic [wstt_pkg::CNT_W-1:0]        count_q;
	logic signed [wstt_pkg::WGT_W-1:0] weight_q [wstt_pkg::NUM_WEIGHTS];
	logic signed [wstt_pkg::VAL_W-1:0] store_q [FACTORS];
	logic [wstt_pkg::INST_W-1:0]       inst_q;
	logic signed [wstt_pkg::PROD_W-1:0] prod_s1;
	logic                              prod_vld_s1;
	logic signed [wstt_pkg::SUM_W-1:0] acc_q;
	logic                              out_valid_q;
	logic                              out_side_q;
	logic [wstt_pkg::INST_W-1:0]       out_inst_q;

	logic [wstt_pkg::CNT_W-1:0]        used_c;
	logic signed [wstt_pkg::VAL_W-1:0] rd_val;
	logic signed [wstt_pkg::WGT_W-1:0] rd_wgt;
	logic signed [wstt_pkg::SUM_W-1:0] thr_pos;
	logic signed [wstt_pkg::SUM_W-1:0] thr_neg;
	logic                              hit_buy;
	logic                              hit_sell;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= wstt_pkg::THR_RESET;
			count_q     <= '0;
			for (int i = 0; i < wstt_pkg::NUM_WEIGHTS; i++) begin
				weight_q[i] <= '0;
			end
		end else if (cfg_valid) begin
			unique case (wstt_pkg::cfg_reg_t'(cfg_index)) inside
				wstt_pkg::REG_THRESHOLD: begin
					threshold_q <= cfg_data[wstt_pkg::THR_W-1:0];
				end
				wstt_pkg::REG_FACTOR_COUNT: begin
					count_q <= cfg_data[wstt_pkg::CNT_W-1:0];
				end
				[wstt_pkg::REG_WEIGHT_0:wstt_pkg::REG_WEIGHT_5]: begin
					weight_q[wstt_pkg::WIDX_W'(cfg_index - wstt_pkg::REG_WEIGHT_0)] <=
						cfg_data[wstt_pkg::WGT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// a count above the store depth acts as the full depth
	assign used_c = (count_q > wstt_pkg::CNT_W'(FACTORS)) ? wstt_pkg::CNT_W'(FACTORS) : count_q;

	// factor store: an order clears every slot, stale ones too
	for (genvar g = 0; g < FACTORS; g++) begin : g_store
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				store_q[g] <= '0;
			end else if (cmd.emit) begin
				store_q[g] <= '0;
			end else if (cmd.load && (in_slot[IDX_W-1:0] == IDX_W'(g))) begin
				store_q[g] <= in_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			inst_q <= in_inst;
		end
	end

	// one product a cycle, registered before the add
	assign rd_val = store_q[cmd.idx[IDX_W-1:0]];
	assign rd_wgt = weight_q[cmd.idx];

	always_ff @(posedge clk) begin
		prod_s1 <= wstt_pkg::PROD_W'(rd_val * rd_wgt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= '0;
		end else if (prod_vld_s1) begin
			acc_q <= acc_q + wstt_pkg::SUM_W'(prod_s1);
		end
	end

	assign thr_pos  = $signed({{(wstt_pkg::SUM_W - wstt_pkg::THR_W){1'b0}}, threshold_q});
	assign thr_neg  = -thr_pos;
	assign hit_buy  = (acc_q >= thr_pos);
	assign hit_sell = (acc_q <= thr_neg);

	// order output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_side_q <= hit_buy ? wstt_pkg::SIDE_BUY : wstt_pkg::SIDE_SELL;
			out_inst_q <= inst_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_side  = out_side_q;
	assign out_inst  = out_inst_q;

	assign sts.slot_ok  = (in_slot < used_c);
	assign sts.used     = used_c;
	assign sts.fire     = hit_buy || hit_sell;
	assign sts.out_free = !out_valid_q || out_ready;

endmodule

// File: rtl/weighted_signal_threshold_trigger.sv
// ----------------------------------------------------------------------------
// weighted_signal_threshold_trigger
// Stores factor updates, forms their weighted sum and issues a buy or sell
// order when the sum crosses the threshold.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  sig_in   in   valid / ready  factor_slot, factor_value, instrument
//  ord_out  out  valid / ready  side, order_instrument
//  cfg      in   valid / ready  reg_index, wdata
//
//  an update to a slot in use (used = slots in use, 0..FACTORS) is stored,
//  then each slot in use goes in turn through the shared multiplier, the
//  product register is drained and the sum is compared
//  an ignored update (slot not in use) is taken and dropped
//  reset clears the factor store and loads register defaults at once
//  a stalled order output holds the block in its compare step only when a
//  new order is ready; otherwise the next update is taken while it waits
//  cfg is always ready
module weighted_signal_threshold_trigger #(
	parameter int FACTORS = wstt_pkg::FACTORS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	wstt_in_if.sink    sig_in,
	wstt_out_if.source ord_out,
	wstt_cfg_if.sink   cfg
);

	wstt_pkg::wstt_cmd_t cmd;
	wstt_pkg::wstt_sts_t sts;

	assign cfg.ready = 1'b1;

	wstt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sig_in.valid),
		.in_ready (sig_in.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	wstt_dp #(
		.FACTORS (FACTORS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.reg_index),
		.cfg_data  (cfg.wdata),
		.in_slot   (sig_in.factor_slot),
		.in_value  (sig_in.factor_value),
		.in_inst   (sig_in.instrument),
		.out_ready (ord_out.ready),
		.out_valid (ord_out.valid),
		.out_side  (ord_out.side),
		.out_inst  (ord_out.order_instrument),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// File: rtl/wstt_chk.sv
// ----------------------------------------------------------------------------
// wstt_chk
// Port-level checks for the trigger, bound to the top level.
// ----------------------------------------------------------------------------
module wstt_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        side,
	input logic [wstt_pkg::INST_W-1:0] order_instrument,
	input logic                        cfg_valid,
	input logic                        cfg_ready
);

	// an order beat holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("order beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(side) && $stable(order_instrument))
		else $error("order payload changed while stalled");

	// a fresh order is only issued from the compare step, when no update is taken
	a_order_from_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("order appeared without a compare step");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("register write refused");

	// an update is never taken while an order is being loaded
	a_no_take_on_rise: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("order loaded in the cycle after an update was taken");

endmodule

bind weighted_signal_threshold_trigger wstt_chk u_wstt_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (sig_in.valid),
	.in_ready         (sig_in.ready),
	.out_valid        (ord_out.valid),
	.out_ready        (ord_out.ready),
	.side             (ord_out.side),
	.order_instrument (ord_out.order_instrument),
	.cfg_valid        (cfg.valid),
	.cfg_ready        (cfg.ready)
);
